// File: rtl/core/fqs_pkg.sv
`timescale 1ns / 1ps
package fqs_pkg;

   localparam int DEPTH_DEF = 64;

   localparam int REQ_W  = 3;
   localparam int WORD_W = 64;
   localparam int POS_W  = 7;
   localparam int STAT_W = 3;
   localparam int IDX_W  = 6;
   localparam int CNT_W  = 7;

   localparam logic [REQ_W-1:0] REQ_INIT   = 3'd0;
   localparam logic [REQ_W-1:0] REQ_ENQ    = 3'd1;
   localparam logic [REQ_W-1:0] REQ_DEQ    = 3'd2;
   localparam logic [REQ_W-1:0] REQ_FRONT  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_BACK   = 3'd4;
   localparam logic [REQ_W-1:0] REQ_SIZE   = 3'd5;
   localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd6;
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd7;

   localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
   localparam logic [STAT_W-1:0] ST_NOINIT = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL   = 3'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd3;
   localparam logic [STAT_W-1:0] ST_BADPOS = 3'd4;

   // one decoded request as it travels from front to back
   typedef struct packed {
      logic [REQ_W-1:0]  op;
      logic              gated;   // needs an initialized queue
      logic [WORD_W-1:0] value;
      logic [POS_W-1:0]  position;
   } cmd_type;

endpackage

// File: rtl/core/fqs_front.sv
`timescale 1ns / 1ps
module fqs_front import fqs_pkg::*; (
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [REQ_W-1:0]    req_type,
   input  logic [WORD_W-1:0]   req_value,
   input  logic [POS_W-1:0]    req_position,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output cmd_type             cmd
);

   always_comb begin
      cmd.op       = req_type;
      cmd.gated    = (req_type inside {[REQ_ENQ:REQ_SIZE]});
      cmd.value    = req_value;
      cmd.position = req_position;
   end

   assign cmd_valid = req_valid;
   assign req_ready = cmd_ready;

endmodule

// File: rtl/core/fqs_cmd_queue.sv
`timescale 1ns / 1ps
module fqs_cmd_queue import fqs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;

   assign in_ready  = (fill_ff != 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

// File: rtl/core/fqs_back.sv
`timescale 1ns / 1ps
module fqs_back import fqs_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  cmd_type           cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [STAT_W-1:0] rsp_status,
   output logic [WORD_W-1:0] rsp_data,
   output logic [IDX_W-1:0]  rsp_index,
   output logic [CNT_W-1:0]  rsp_count
);

   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int SW   = CW + 1;
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_KEY  = 2'd2;
   localparam logic [1:0] S_SCAN = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [PW-1:0]     head_ff, head_in;
   logic [CW-1:0]     occ_ff, occ_in;
   logic              init_ff, init_in;
   logic [PW-1:0]     scan_ff, scan_in;
   logic [WORD_W-1:0] key_ff, key_in;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;
   logic [PW-1:0]     rd_addr;
   logic              wr_en;
   logic [PW-1:0]     wr_addr;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0] rsp_data_ff, rsp_data_in;
   logic [IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic              rsp_load;

   logic              go;
   logic [CMPW-1:0]   pos_ext, occ_ext;
   logic [CW-1:0]     pos_off;

   // head plus offset, wrapped once; both terms stay below DEPTH
   function automatic logic [PW-1:0] slot(input logic [PW-1:0] head,
                                          input logic [CW-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(head) + SW'(off);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[PW-1:0];
   endfunction

   assign go        = (state_ff == S_IDLE) && cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign cmd_ready = go;
   assign pos_ext   = CMPW'(cmd.position);
   assign occ_ext   = CMPW'(occ_ff);
   assign pos_off   = CW'(pos_ext - CMPW'(1));

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      occ_in        = occ_ff;
      init_in       = init_ff;
      scan_in       = scan_ff;
      key_in        = key_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      rsp_load      = 1'b0;
      rsp_status_in = ST_OK;
      rsp_data_in   = '0;
      rsp_index_in  = '0;
      rsp_count_in  = CNT_W'(occ_ff);

      case (state_ff)
         S_IDLE: begin
            if (go) begin
               if (cmd.gated && !init_ff) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = ST_NOINIT;
               end else begin
                  case (cmd.op)
                     REQ_INIT: begin
                        init_in      = 1'b1;
                        head_in      = '0;
                        occ_in       = '0;
                        rsp_load     = 1'b1;
                        rsp_count_in = '0;
                     end
                     REQ_ENQ: begin
                        rsp_load = 1'b1;
                        if (occ_ff == CW'(DEPTH)) begin
                           rsp_status_in = ST_FULL;
                        end else begin
                           wr_en        = 1'b1;
                           wr_addr      = slot(head_ff, occ_ff);
                           occ_in       = occ_ff + CW'(1);
                           rsp_count_in = CNT_W'(occ_ff + CW'(1));
                        end
                     end
                     REQ_DEQ, REQ_FRONT, REQ_BACK: begin
                        if (occ_ff == '0) begin
                           rsp_load      = 1'b1;
                           rsp_status_in = ST_EMPTY;
                        end else begin
                           state_in = S_READ;
                           if (cmd.op == REQ_BACK) begin
                              rd_addr = slot(head_ff, occ_ff - CW'(1));
                           end else begin
                              rd_addr = head_ff;
                           end
                           if (cmd.op == REQ_DEQ) begin
                              head_in = slot(head_ff, CW'(1));
                              occ_in  = occ_ff - CW'(1);
                           end
                        end
                     end
                     REQ_SIZE: begin
                        rsp_load = 1'b1;
                     end
                     REQ_SEARCH: begin
                        if (occ_ff == '0) begin
                           rsp_load      = 1'b1;
                           rsp_status_in = ST_EMPTY;
                        end else if (pos_ext == '0 || pos_ext > occ_ext) begin
                           rsp_load      = 1'b1;
                           rsp_status_in = ST_BADPOS;
                        end else begin
                           rd_addr  = slot(head_ff, pos_off);
                           state_in = S_KEY;
                        end
                     end
                     default: begin
                        rsp_load = 1'b1;
                        if (occ_ff == '0) begin
                           rsp_status_in = ST_EMPTY;
                        end else begin
                           occ_in       = '0;
                           head_in      = '0;
                           rsp_count_in = '0;
                        end
                     end
                  endcase
               end
            end
         end
         S_READ: begin
            rsp_load    = 1'b1;
            rsp_data_in = rd_data_ff;
            state_in    = S_IDLE;
         end
         S_KEY: begin
            key_in   = rd_data_ff;
            rd_addr  = head_ff;
            scan_in  = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // data for scan_ff arrives now; fetch the next one in case of a miss
            if (rd_data_ff == key_ff) begin
               rsp_load     = 1'b1;
               rsp_index_in = IDX_W'(scan_ff);
               state_in     = S_IDLE;
            end else begin
               scan_in = scan_ff + PW'(1);
               rd_addr = slot(head_ff, CW'(scan_ff) + CW'(1));
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         init_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      key_ff  <= key_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= cmd.value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

// File: rtl/core/fifo_queue_with_search.sv
`timescale 1ns / 1ps
// Bounded FIFO of DEPTH 64-bit words with init, enqueue, dequeue, front/back
// peek, size, search and clear; every request yields one result with status,
// data, index and occupancy. Requests are decoded and parked in a two-entry
// command queue; the execution side owns the word store, a memory with separate
// read and write addresses and registered read data. Init, enqueue, size, clear
// and every error are answered straight from the idle state; dequeue and peeks
// pass through a read state for the registered store read; a search first reads
// the key word, then scans from the head with one store read per candidate. At
// the earliest, rsp_valid rises at the clock edge after the one that accepts the
// request; while a result waits on rsp_ready, the request queue keeps accepting
// until its two entries are full. The store needs no clearing after reset.
module fifo_queue_with_search import fqs_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [REQ_W-1:0]  req_type,
   input  logic [WORD_W-1:0] req_value,
   input  logic [POS_W-1:0]  req_position,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [STAT_W-1:0] rsp_status,
   output logic [WORD_W-1:0] rsp_data,
   output logic [IDX_W-1:0]  rsp_index,
   output logic [CNT_W-1:0]  rsp_count
);

   logic    f_valid, f_ready;
   cmd_type f_cmd;
   logic    q_valid, q_ready;
   cmd_type q_cmd;

   fqs_front u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_value    (req_value),
      .req_position (req_position),
      .cmd_valid    (f_valid),
      .cmd_ready    (f_ready),
      .cmd          (f_cmd)
   );

   fqs_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_cmd    (f_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_cmd   (q_cmd)
   );

   fqs_back #(.DEPTH(DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd_ready  (q_ready),
      .cmd        (q_cmd),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_index  (rsp_index),
      .rsp_count  (rsp_count)
   );

endmodule

// File: rtl/core/fqs_checker.sv
`timescale 1ns / 1ps
module fqs_checker import fqs_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [STAT_W-1:0] rsp_status,
   input logic [WORD_W-1:0] rsp_data,
   input logic [IDX_W-1:0]  rsp_index,
   input logic [CNT_W-1:0]  rsp_count
);

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_data)
         && $stable(rsp_index) && $stable(rsp_count))
      else $error("result changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_data == '0 && rsp_index == '0)
      else $error("error result carries data or index");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_count == FULL_COUNT)
      else $error("full reported below capacity");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_count == '0)
      else $error("empty reported with words held");

endmodule

bind fifo_queue_with_search fqs_checker #(.DEPTH(DEPTH)) u_fqs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_status (rsp_status),
   .rsp_data   (rsp_data),
   .rsp_index  (rsp_index),
   .rsp_count  (rsp_count)
);
